/* sv/fdf_pkg.sv */
// shared types and constants for the 8-tap direct-form fir filter
// no dependencies; imported by every module of the block
`default_nettype none

package fdf_pkg;

    // coefficient storage is fixed at eight taps of q1.15
    localparam int NCOEF       = 8;
    localparam int COEF_BITS   = 16;
    localparam int COEF_IDX_W  = $clog2(NCOEF);

    // defaults handed to the top level parameters
    localparam int TAPS_DEFAULT        = 8;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // q1.15 scaling: add half an output unit, then drop the fraction
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

    // apb register map: one 32-bit word per coefficient
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = COEF_IDX_W + 2;

    localparam logic signed [COEF_BITS-1:0] COEF0_RESET = 16'sh7FFF;
    localparam logic signed [COEF_BITS-1:0] COEFN_RESET = 16'sh0000;

    // load enables for the registered adder tree levels
    typedef struct packed {
        logic lvl1;
        logic lvl2;
        logic lvl3;
    } tree_en_t;

    function automatic logic signed [COEF_BITS-1:0] coef_reset(input int idx);
        logic signed [COEF_BITS-1:0] val;
        val = (idx == 0) ? COEF0_RESET : COEFN_RESET;
        return val;
    endfunction

endpackage

`default_nettype wire

/* sv/fdf_cell.sv */
// one tap cell: holds one registered product and, unless it is the last cell, one history sample
// depends on fdf_pkg
`default_nettype none

module fdf_cell #(
    parameter int SAMPLE_BITS = fdf_pkg::SAMPLE_BITS_DEFAULT,
    parameter bit FIRST       = 1'b0,
    parameter bit HOLD        = 1'b1
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic signed [fdf_pkg::COEF_BITS-1:0]  coef,
    input  wire logic signed [SAMPLE_BITS-1:0]         tap_in,
    input  wire logic                                  start,
    input  wire logic                                  shift,
    input  wire logic                                  prod_en,
    output logic signed [SAMPLE_BITS-1:0]              sample_out,
    output logic signed [SAMPLE_BITS+fdf_pkg::COEF_BITS-1:0] prod_out
);
    import fdf_pkg::*;

    localparam int PW = SAMPLE_BITS + COEF_BITS;

    logic signed [SAMPLE_BITS-1:0] tap;
    logic signed [PW-1:0]          prod_reg;
    logic signed [PW-1:0]          prod_next;

    // a block start zeroes every earlier sample, the new one passes
    always_comb
    begin
        tap       = (FIRST || !start) ? tap_in : '0;
        prod_next = PW'(coef) * PW'(tap);
    end

    always_ff @(posedge clk)
    begin
        if (prod_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_out = prod_reg;

    generate
        if (HOLD)
        begin : g_hold
            logic signed [SAMPLE_BITS-1:0] sample_reg;
            logic signed [SAMPLE_BITS-1:0] sample_next;

            assign sample_next = shift ? tap : sample_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sample_reg <= '0;
                end
                else
                begin
                    sample_reg <= sample_next;
                end
            end

            assign sample_out = sample_reg;
        end
        else
        begin : g_end
            // end of the line: nothing left to hand on
            assign sample_out = '0;
        end
    endgenerate

endmodule

`default_nettype wire

/* sv/fdf_adder_tree.sv */
// three-level registered adder tree over the eight tap products
// depends on fdf_pkg (tree_en_t, NCOEF)
`default_nettype none

module fdf_adder_tree #(
    parameter int SAMPLE_BITS = fdf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                                                clk,
    input  wire fdf_pkg::tree_en_t                                   en,
    input  wire logic signed [SAMPLE_BITS+fdf_pkg::COEF_BITS-1:0]    prod [fdf_pkg::NCOEF],
    output logic signed [SAMPLE_BITS+fdf_pkg::COEF_BITS+2:0]         sum
);
    import fdf_pkg::*;

    localparam int PW = SAMPLE_BITS + COEF_BITS;
    localparam int N1 = NCOEF / 2;
    localparam int N2 = NCOEF / 4;

    logic signed [PW:0]   lvl1_reg  [N1];
    logic signed [PW:0]   lvl1_next [N1];
    logic signed [PW+1:0] lvl2_reg  [N2];
    logic signed [PW+1:0] lvl2_next [N2];
    logic signed [PW+2:0] lvl3_reg;
    logic signed [PW+2:0] lvl3_next;

    always_comb
    begin
        for (int i = 0; i < N1; i++)
        begin
            lvl1_next[i] = (PW+1)'(prod[2*i]) + (PW+1)'(prod[2*i+1]);
        end
        for (int i = 0; i < N2; i++)
        begin
            lvl2_next[i] = (PW+2)'(lvl1_reg[2*i]) + (PW+2)'(lvl1_reg[2*i+1]);
        end
        lvl3_next = (PW+3)'(lvl2_reg[0]) + (PW+3)'(lvl2_reg[1]);
    end

    always_ff @(posedge clk)
    begin
        if (en.lvl1)
        begin
            lvl1_reg <= lvl1_next;
        end
        if (en.lvl2)
        begin
            lvl2_reg <= lvl2_next;
        end
        if (en.lvl3)
        begin
            lvl3_reg <= lvl3_next;
        end
    end

    assign sum = lvl3_reg;

endmodule

`default_nettype wire

/* sv/fir_filter_direct_form_top.sv */
// pipeline registers: product, three adder levels and the rounding/saturation output register
// throughput: one sample beat per cycle while result_stall does not back the pipeline up
// reset: history cleared to zero, coef_0 = 0x7fff, other coefficients zero, pipeline empty
// depends on fdf_pkg, fdf_cell, fdf_adder_tree
`default_nettype none

module fir_filter_direct_form_top #(
    parameter int TAPS        = fdf_pkg::TAPS_DEFAULT,
    parameter int SAMPLE_BITS = fdf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample channel
    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]      sample,
    input  wire logic                               block_start,
    // result channel
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [SAMPLE_BITS-1:0]           filtered,
    output logic                                    saturated,
    // apb configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fdf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [fdf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [fdf_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready
);
    import fdf_pkg::*;

    localparam int PW = SAMPLE_BITS + COEF_BITS;  // one product
    localparam int SW = PW + 3;                   // sum of eight products
    localparam int RW = SW + 1;                   // sum plus rounding half
    localparam int HD = (TAPS > 1) ? TAPS - 1 : 1;

    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [RW-1:0]          LIM_HI  = RW'(OUT_MAX);
    localparam logic signed [RW-1:0]          LIM_LO  = RW'(OUT_MIN);

    // ------------------------------------------------------------------
    // coefficient registers over apb; the user writes them only while the filter is idle, unchecked by the block
    // ------------------------------------------------------------------
    logic signed [COEF_BITS-1:0] coef_reg [NCOEF];
    logic [COEF_IDX_W-1:0]       reg_idx;
    logic                        cfg_wr;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = {{(APB_DATA_W-COEF_BITS){1'b0}}, coef_reg[reg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++)
            begin
                coef_reg[i] <= coef_reset(i);
            end
        end
        else if (cfg_wr)
        begin
            coef_reg[reg_idx] <= pwdata[COEF_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: each stage loads when it is empty or its
    // successor loads, so bubbles close up behind a stalled result
    // ------------------------------------------------------------------
    logic     prod_valid_reg, lvl1_valid_reg, lvl2_valid_reg, lvl3_valid_reg;
    logic     result_valid_reg;
    logic     en_out, en_lvl3, en_lvl2, en_lvl1, en_prod;
    logic     accept, out_beat;
    tree_en_t tree_en;

    always_comb
    begin
        en_out  = !result_valid_reg || !result_stall;
        en_lvl3 = !lvl3_valid_reg   || en_out;
        en_lvl2 = !lvl2_valid_reg   || en_lvl3;
        en_lvl1 = !lvl1_valid_reg   || en_lvl2;
        en_prod = !prod_valid_reg   || en_lvl1;

        tree_en.lvl1 = en_lvl1;
        tree_en.lvl2 = en_lvl2;
        tree_en.lvl3 = en_lvl3;
    end

    assign sample_stall = !en_prod;
    assign accept       = sample_valid && en_prod;
    assign out_beat     = result_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg   <= 1'b0;
            lvl1_valid_reg   <= 1'b0;
            lvl2_valid_reg   <= 1'b0;
            lvl3_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_prod)
            begin
                prod_valid_reg <= sample_valid;
            end
            if (en_lvl1)
            begin
                lvl1_valid_reg <= prod_valid_reg;
            end
            if (en_lvl2)
            begin
                lvl2_valid_reg <= lvl1_valid_reg;
            end
            if (en_lvl3)
            begin
                lvl3_valid_reg <= lvl2_valid_reg;
            end
            if (en_out)
            begin
                result_valid_reg <= lvl3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // row of tap cells: the delay line shifts once per accepted beat,
    // every cell multiplies its tap by its coefficient in the same cycle
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] hist [HD];
    logic signed [PW-1:0]          prod [NCOEF];

    generate
        for (genvar k = 0; k < NCOEF; k++)
        begin : g_tap
            if (k < TAPS)
            begin : g_cell
                logic signed [SAMPLE_BITS-1:0] tap_src;
                logic signed [SAMPLE_BITS-1:0] hand_on;

                if (k == 0)
                begin : g_src_new
                    assign tap_src = sample;
                end
                else
                begin : g_src_hist
                    assign tap_src = hist[k-1];
                end

                fdf_cell #(
                    .SAMPLE_BITS (SAMPLE_BITS),
                    .FIRST       (k == 0),
                    .HOLD        (k < TAPS - 1)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .coef       (coef_reg[k]),
                    .tap_in     (tap_src),
                    .start      (block_start),
                    .shift      (accept),
                    .prod_en    (en_prod),
                    .sample_out (hand_on),
                    .prod_out   (prod[k])
                );

                if (k < TAPS - 1)
                begin : g_link
                    assign hist[k] = hand_on;
                end
            end
            else
            begin : g_unused
                // coefficients past the tap count are stored but never applied
                assign prod[k] = '0;
            end
        end

        if (TAPS == 1)
        begin : g_no_hist
            assign hist[0] = '0;
        end
    endgenerate

    // ------------------------------------------------------------------
    // sum of products, then round to nearest (ties up), scale and clip
    // ------------------------------------------------------------------
    logic signed [SW-1:0]          acc_sum;
    logic signed [RW-1:0]          rounded;
    logic signed [RW-1:0]          scaled;
    logic signed [SAMPLE_BITS-1:0] filtered_reg, filtered_next;
    logic                          saturated_reg, saturated_next;

    fdf_adder_tree #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tree (
        .clk  (clk),
        .en   (tree_en),
        .prod (prod),
        .sum  (acc_sum)
    );

    always_comb
    begin
        rounded = RW'(acc_sum) + RW'(ROUND_HALF);
        scaled  = rounded >>> FRAC_BITS;
        if (scaled > LIM_HI)
        begin
            filtered_next  = OUT_MAX;
            saturated_next = 1'b1;
        end
        else if (scaled < LIM_LO)
        begin
            filtered_next  = OUT_MIN;
            saturated_next = 1'b1;
        end
        else
        begin
            filtered_next  = scaled[SAMPLE_BITS-1:0];
            saturated_next = 1'b0;
        end
    end

    // output register parts the result channel from the tree
    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            filtered_reg  <= filtered_next;
            saturated_reg <= saturated_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign filtered     = filtered_reg;
    assign saturated    = saturated_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // items in flight change only by accepted and delivered beats
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (int'($countones({prod_valid_reg, lvl1_valid_reg, lvl2_valid_reg,
                                   lvl3_valid_reg, result_valid_reg}))
                  == int'($past($countones({prod_valid_reg, lvl1_valid_reg,
                                            lvl2_valid_reg, lvl3_valid_reg,
                                            result_valid_reg})))
                     + int'($past(accept)) - int'($past(out_beat))))
        else $error("pipeline occupancy out of step with beats");

    // a clipped result sits exactly on one of the range bounds
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && saturated_reg) |->
            (filtered_reg == OUT_MAX || filtered_reg == OUT_MIN))
        else $error("saturated result not at a range bound");

    generate
        if (TAPS > 1)
        begin : g_hist_chk
            // newest history entry is the sample of the last accepted beat
            a_hist_head: assert property (@(posedge clk) disable iff (!rst_n)
                accept |=> (hist[0] == $past(sample)))
                else $error("delay line did not take the accepted sample");
        end
    endgenerate

endmodule

`default_nettype wire

/* bench/tb_fir_filter_direct_form_top.sv */
// self-checking testbench for fir_filter_direct_form_top: an 8-tap q1.15 fir filter
// drives sample beats and apb coefficient writes, predicts each filtered beat and checks it
// depends on fdf_pkg and the filter rtl

module tb_fir_filter_direct_form_top;

    import fdf_pkg::*;

    // bench sizing, fixed to the default build of the block
    localparam int SW           = SAMPLE_BITS_DEFAULT;
    localparam int ADDR_W       = APB_ADDR_W;
    localparam int LIMIT_CYCLES = 400000;
    // margin after the pipeline has drained, to catch stray result beats
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 30;
    localparam longint OUT_MAX  = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint OUT_MIN  = -(64'sd1 <<< (SW - 1));

    typedef logic signed [SW-1:0]        sample_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef coef_t coef_set_t [NCOEF];

    // one filtered result beat as the block should deliver it
    typedef struct packed {
        logic signed [SW-1:0] filtered;
        logic                 saturated;
    } fir_result_t;

    // how a random coefficient set is drawn
    typedef enum int {
        COEF_FULL,
        COEF_EXTREME,
        COEF_SMALL,
        COEF_ONE_TAP
    } coef_mix_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports, every input known from time zero
    // ------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    sample_t                sample       = '0;
    logic                   block_start  = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic signed [SW-1:0]   filtered;
    logic                   saturated;
    logic                   psel         = 1'b0;
    logic                   penable      = 1'b0;
    logic                   pwrite       = 1'b0;
    logic [ADDR_W-1:0]      paddr        = '0;
    logic [APB_DATA_W-1:0]  pwdata       = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // ------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------
    // filter state mirrored by the bench: coefficients and delay line, newest first
    coef_t       tap_coef   [NCOEF];
    sample_t     delay_line [NCOEF-1];
    // results still owed by the block, oldest first
    fir_result_t expected_results [$];
    fir_result_t head_result;

    int  error_count   = 0;
    int  beats_in      = 0;
    int  beats_out     = 0;
    int  clipped_beats = 0;
    int  coef_writes   = 0;
    int  cycle_count   = 0;
    int  stall_hold    = 0;
    // random gaps on the sample side and random stall on the result side
    bit  gaps_enabled  = 1'b1;

    fir_filter_direct_form_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .block_start  (block_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .saturated    (saturated),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 10 time unit period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, expected_results.size());
            $display("tb_fir_filter_direct_form_top failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // one line per mismatch, capped so a broken block cannot flood the log
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // sample values: mostly full range, with extremes and small values mixed in
    function automatic sample_t random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return sample_t'($urandom_range(0, 65535));
        else if (r < 85)
        begin
            case ($urandom_range(0, 4))
                0:       return sample_t'(OUT_MAX);
                1:       return sample_t'(OUT_MIN);
                2:       return '0;
                3:       return sample_t'(-1);
                default: return sample_t'(1);
            endcase
        end
        return sample_t'(int'($urandom_range(0, 512)) - 256);
    endfunction

    // filter output for one accepted sample; advances the mirrored delay line
    function automatic fir_result_t compute_fir_output(input sample_t x, input logic clear);
        longint      acc;
        longint      y;
        fir_result_t r;
        if (clear)
            foreach (delay_line[k])
                delay_line[k] = '0;
        acc = longint'(tap_coef[0]) * longint'(x);
        for (int k = 1; k < NCOEF; k++)
            acc += longint'(tap_coef[k]) * longint'(delay_line[k-1]);
        // add half an output unit, then floor back to sample scale
        y = (acc + ROUND_HALF) >>> FRAC_BITS;
        r.saturated = 1'b0;
        if (y > OUT_MAX)
        begin
            y = OUT_MAX;
            r.saturated = 1'b1;
        end
        else if (y < OUT_MIN)
        begin
            y = OUT_MIN;
            r.saturated = 1'b1;
        end
        r.filtered = sample_t'(y);
        for (int k = NCOEF - 2; k > 0; k--)
            delay_line[k] = delay_line[k-1];
        delay_line[0] = x;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------

    // present one sample beat and hold it until the block takes it;
    // valid stays high on return so a following beat can go straight out
    task automatic send_sample(input sample_t value, input logic clear);
        int gap;
        gap = gaps_enabled ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        block_start  <= clear;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        expected_results.push_back(compute_fir_output(value, clear));
        beats_in++;
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // apb side
    // ------------------------------------------------------------------

    // setup then access phase; junk in the upper word bits must be ignored
    task automatic write_coef(input int idx, input coef_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tap_coef[idx] = value;
        coef_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_coef(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[COEF_BITS-1:0] !== tap_coef[idx])
            report_mismatch($sformatf("coef_%0d readback", idx),
                            longint'(coef_t'(prdata[COEF_BITS-1:0])), longint'(tap_coef[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // new coefficient set, only once the pipeline is empty; read it back
    task automatic load_coefs(input coef_set_t set);
        wait_drained();
        for (int i = 0; i < NCOEF; i++)
            write_coef(i, set[i]);
        for (int i = 0; i < NCOEF; i++)
            read_coef(i);
    endtask

    function automatic coef_set_t random_coefs(input coef_mix_t mix);
        coef_set_t set;
        int        hot;
        hot = $urandom_range(0, NCOEF - 1);
        for (int i = 0; i < NCOEF; i++)
        begin
            case (mix)
                COEF_FULL:
                    set[i] = coef_t'($urandom_range(0, 65535));
                COEF_EXTREME:
                    case ($urandom_range(0, 2))
                        0:       set[i] = coef_t'(16'sh7FFF);
                        1:       set[i] = coef_t'(16'sh8000);
                        default: set[i] = '0;
                    endcase
                COEF_SMALL:
                    set[i] = coef_t'(int'($urandom_range(0, 8192)) - 4096);
                default:
                    set[i] = (i == hot) ? coef_t'($urandom_range(0, 65535)) : '0;
            endcase
        end
        return set;
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // result stall in bursts of random length, dropped once the current burst ends while gaps are disabled
    always @(posedge clk)
    begin
        if (stall_hold != 0)
            stall_hold--;
        else if (!gaps_enabled)
            result_stall <= 1'b0;
        else
        begin
            result_stall <= ($urandom_range(0, 2) == 0);
            stall_hold   = pick_gap();
        end
    end

    // every accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            beats_out++;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result beat, filtered", longint'(filtered), 0);
            else
            begin
                head_result = expected_results.pop_front();
                if (filtered !== head_result.filtered)
                    report_mismatch("filtered", longint'(filtered),
                                    longint'(head_result.filtered));
                if (saturated !== head_result.saturated)
                    report_mismatch("saturated", longint'(saturated),
                                    longint'(head_result.saturated));
                if (head_result.saturated)
                    clipped_beats++;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // coefficients as left by reset: coef_0 just under unity, rest zero
    task automatic test_reset_coefs();
        send_sample(sample_t'(OUT_MAX), 1'b0);
        send_sample(sample_t'(OUT_MIN), 1'b0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(-1), 1'b1);
        send_sample(sample_t'(12345), 1'b0);
    endtask

    // half-gain taps put the first sum exactly on a positive rounding tie
    task automatic test_rounding_ties();
        coef_set_t set;
        foreach (set[i])
            set[i] = '0;
        set[0] = coef_t'(16384);
        set[1] = coef_t'(16384);
        load_coefs(set);
        send_sample(sample_t'(1), 1'b1);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(3), 1'b0);
        send_sample(sample_t'(-3), 1'b0);
        send_sample(sample_t'(OUT_MAX), 1'b0);
    endtask

    // clipping at both bounds, including a single most-negative product
    task automatic test_saturation();
        coef_set_t set;
        foreach (set[i])
            set[i] = coef_t'(16'sh7FFF);
        load_coefs(set);
        send_sample(sample_t'(OUT_MAX), 1'b1);
        send_sample(sample_t'(OUT_MAX), 1'b0);
        send_sample(sample_t'(OUT_MIN), 1'b0);
        foreach (set[i])
            set[i] = coef_t'(16'sh8000);
        load_coefs(set);
        // -1.0 times the most negative sample overflows by one unit
        send_sample(sample_t'(OUT_MIN), 1'b1);
        send_sample(sample_t'(OUT_MAX), 1'b1);
        send_sample(sample_t'(OUT_MAX), 1'b0);
        send_sample(sample_t'(OUT_MAX), 1'b0);
    endtask

    // impulse walks through distinct taps; block start wipes the history mid-stream
    task automatic test_history_clear();
        coef_set_t set;
        foreach (set[i])
            set[i] = coef_t'(((i % 2) ? -4096 : 4096) * (i + 1) - i);
        load_coefs(set);
        send_sample(sample_t'(OUT_MAX), 1'b1);
        send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        send_sample(sample_t'(OUT_MIN), 1'b0);
        send_sample(sample_t'(100), 1'b1);
        send_sample('0, 1'b0);
    endtask

    // random streams over several coefficient mixes; one pause lets the block run dry
    task automatic test_random_phases(input int per_phase);
        coef_mix_t mixes [5];
        mixes = '{COEF_FULL, COEF_EXTREME, COEF_SMALL, COEF_ONE_TAP, COEF_FULL};
        foreach (mixes[p])
        begin
            load_coefs(random_coefs(mixes[p]));
            for (int n = 0; n < per_phase; n++)
            begin
                if (p == 2 && n == per_phase / 2)
                    wait_drained();
                send_sample(random_sample(), ($urandom_range(0, 24) == 0));
            end
        end
    endtask

    // full rate: no gaps, no stall
    task automatic test_back_to_back(input int count);
        load_coefs(random_coefs(COEF_FULL));
        gaps_enabled = 1'b0;
        for (int n = 0; n < count; n++)
            send_sample(random_sample(), (n == 0) || ($urandom_range(0, 30) == 0));
        wait_drained();
        gaps_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        // mirror the reset state of the block
        foreach (tap_coef[i])
            tap_coef[i] = (i == 0) ? COEF0_RESET : COEFN_RESET;
        foreach (delay_line[i])
            delay_line[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_coefs();
        test_rounding_ties();
        test_saturation();
        test_history_clear();
        test_random_phases(130);
        test_back_to_back(100);

        // nothing owed, then a margin for stray beats
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d sample beats and %0d result beats, %0d of them clipped",
                 beats_in, beats_out, clipped_beats);
        $display("over %0d coefficient writes: reset, tie, clipping, history clear, random mixes",
                 coef_writes);
        if (error_count == 0 && expected_results.size() == 0)
            $display("tb_fir_filter_direct_form_top passed");
        else
            $display("tb_fir_filter_direct_form_top failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/fdf_pkg.sv
sv/fdf_cell.sv
sv/fdf_adder_tree.sv
sv/fir_filter_direct_form_top.sv
bench/tb_fir_filter_direct_form_top.sv
